@@ design/cct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg
// Types and constants shared by the circle collision tester and its units.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam logic CMD_CIRCLE  = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    localparam int T_BITS   = 30;
    localparam int DEN_BITS = 65;
    localparam int LEN_BITS = 32;
    localparam int RAD_BITS = 63;
    localparam int QUO_BITS = 31;
    localparam int UNIT_Q14 = 16384;

    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_DIV
    } t_seg_sel;

    typedef struct packed {
        logic                cmd;
        logic                hit_c;
        t_seg_sel            sel;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic        [30:0]  qr;
        logic signed [31:0]  sx;
        logic signed [31:0]  sy;
        logic        [30:0]  sr;
        logic signed [31:0]  ex;
        logic signed [31:0]  ey;
        logic signed [32:0]  vx;
        logic signed [32:0]  vy;
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
    } t_front;

    typedef struct packed {
        logic                cmd;
        logic                hit;
        logic        [30:0]  ax;
        logic        [30:0]  ay;
        logic                neg_x;
        logic                neg_y;
        logic signed [31:0]  base_x;
        logic signed [31:0]  base_y;
        logic        [30:0]  sr;
    } t_back;

    typedef struct packed {
        logic                cmd;
        logic                hit;
        logic                neg_x;
        logic                neg_y;
        logic signed [31:0]  base_x;
        logic signed [31:0]  base_y;
        logic                len_zero;
    } t_tail;

endpackage

@@ design/circle_collision_tester.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_collision_tester
// Tests a circle against a second circle or a line segment and returns a hit
// flag, a contact point and a unit normal.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while o_stall is low and returns
// the results in order. Most of the pipeline lies in three pipelined units
// that work one bit per stage: the 30-stage divider for the segment parameter,
// the 32-stage square root for the normal length, and the 31-stage dividers
// for the normal and contact scaling. The whole pipeline holds while a result
// waits at the output with stall high.
module circle_collision_tester #(
    parameter int TOUCH_EPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_query_cx,
    input  logic signed [31:0] i_query_cy,
    input  logic        [30:0] i_query_radius,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic        [30:0] i_second_radius,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic signed [31:0] o_contact_x,
    output logic signed [31:0] o_contact_y,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y
);

    localparam int          TB   = cct_pkg::T_BITS;
    localparam int          QB   = cct_pkg::QUO_BITS;
    localparam int          LB   = cct_pkg::LEN_BITS;
    localparam logic [32:0] EPS  = 33'(TOUCH_EPS);
    localparam logic [63:0] EPS2 = 64'(TOUCH_EPS) * 64'(TOUCH_EPS);

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] b,
                                                   input logic [30:0] q,
                                                   input logic neg);
        logic signed [32:0] s;
        s = neg ? ({b[31], b} - {2'b00, q}) : ({b[31], b} + {2'b00, q});
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [15:0] unit_comp(input logic [30:0] q,
                                                     input logic neg);
        logic [15:0] c;
        c = (q > 31'(cct_pkg::UNIT_Q14)) ? 16'(cct_pkg::UNIT_Q14) : q[15:0];
        return neg ? -c : c;
    endfunction

    logic adv;

    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // Stage 1: differences.
    logic            r1_v;
    cct_pkg::t_front r1_f;
    logic [31:0]     r1_rs;

    // Stage 2: products.
    logic              r2_v;
    cct_pkg::t_front   r2_f;
    logic [31:0]       r2_rs;
    logic [31:0]       r2_ux, r2_uy;
    logic [63:0]       r2_ux2, r2_uy2, r2_rs2;
    logic signed [65:0] r2_wdx, r2_wdy;
    logic [63:0]       r2_ddx, r2_ddy;

    // Stage 3: dot products and segment case.
    logic              r3_v;
    cct_pkg::t_front   r3_f;
    logic [64:0]       r3_num;
    logic [64:0]       r3_den;
    logic signed [66:0] s3_num;
    logic [64:0]       s3_den;
    logic [64:0]       s3_dist2;
    cct_pkg::t_seg_sel s3_sel;
    cct_pkg::t_front   s3_f;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_f.cmd   <= i_cmd;
            r1_f.hit_c <= 1'b0;
            r1_f.sel   <= cct_pkg::SEL_START;
            r1_f.cx    <= i_query_cx;
            r1_f.cy    <= i_query_cy;
            r1_f.qr    <= i_query_radius;
            r1_f.sx    <= i_second_x;
            r1_f.sy    <= i_second_y;
            r1_f.sr    <= i_second_radius;
            r1_f.ex    <= i_end_x;
            r1_f.ey    <= i_end_y;
            r1_f.vx    <= {i_query_cx[31], i_query_cx} - {i_second_x[31], i_second_x};
            r1_f.vy    <= {i_query_cy[31], i_query_cy} - {i_second_y[31], i_second_y};
            r1_f.dx    <= {i_end_x[31], i_end_x} - {i_second_x[31], i_second_x};
            r1_f.dy    <= {i_end_y[31], i_end_y} - {i_second_y[31], i_second_y};
            r1_rs      <= {1'b0, i_query_radius} + {1'b0, i_second_radius};

            r2_f   <= r1_f;
            r2_rs  <= r1_rs;
            r2_ux  <= mag33(r1_f.vx);
            r2_uy  <= mag33(r1_f.vy);
            r2_ux2 <= 64'(mag33(r1_f.vx)) * 64'(mag33(r1_f.vx));
            r2_uy2 <= 64'(mag33(r1_f.vy)) * 64'(mag33(r1_f.vy));
            r2_rs2 <= 64'(r1_rs) * 64'(r1_rs);
            r2_wdx <= 66'(r1_f.vx) * 66'(r1_f.dx);
            r2_wdy <= 66'(r1_f.vy) * 66'(r1_f.dy);
            r2_ddx <= 64'(mag33(r1_f.dx)) * 64'(mag33(r1_f.dx));
            r2_ddy <= 64'(mag33(r1_f.dy)) * 64'(mag33(r1_f.dy));

            r3_f   <= s3_f;
            r3_num <= s3_num[64:0];
            r3_den <= s3_den;
        end
    end

    assign s3_num   = 67'(r2_wdx) + 67'(r2_wdy);
    assign s3_den   = {1'b0, r2_ddx} + {1'b0, r2_ddy};
    assign s3_dist2 = {1'b0, r2_ux2} + {1'b0, r2_uy2};

    always_comb begin
        if ((s3_den == '0) || (s3_num <= 67'sd0)) begin
            s3_sel = cct_pkg::SEL_START;
        end else if (s3_num >= $signed({2'b00, s3_den})) begin
            s3_sel = cct_pkg::SEL_END;
        end else begin
            s3_sel = cct_pkg::SEL_DIV;
        end
    end

    always_comb begin
        s3_f       = r2_f;
        s3_f.hit_c = (r2_ux <= r2_rs) && (r2_uy <= r2_rs) && (s3_dist2 <= {1'b0, r2_rs2});
        s3_f.sel   = s3_sel;
    end

    // Segment parameter t = floor(num * 2^30 / den).
    logic [TB-1:0]   t_quo;
    logic            dA_v;
    cct_pkg::t_front dA_f;

    cct_div #(
        .DW(cct_pkg::DEN_BITS),
        .QW(TB)
    ) u_tdiv (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ({r3_num, TB'(0)}),
        .i_den (r3_den),
        .o_quo (t_quo)
    );

    cct_delay #(
        .W    ($bits(cct_pkg::t_front)),
        .DEPTH(TB)
    ) u_tdly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_valid(r3_v),
        .i_data (r3_f),
        .o_valid(dA_v),
        .o_data (dA_f)
    );

    // Stage A: d * t.
    logic            rA_v;
    cct_pkg::t_front rA_f;
    logic [61:0]     rA_px, rA_py;

    // Stage B: nearest point.
    logic               rB_v;
    cct_pkg::t_front    rB_f;
    logic signed [31:0] rB_qx, rB_qy;
    logic [62:0]        b_sum_x, b_sum_y;
    logic [33:0]        b_off_x, b_off_y;
    logic signed [31:0] b_qx, b_qy;

    assign b_sum_x = {1'b0, rA_px} + (63'(1) << (TB - 1));
    assign b_sum_y = {1'b0, rA_py} + (63'(1) << (TB - 1));
    assign b_off_x = rA_f.dx[32] ? ({{2{rA_f.sx[31]}}, rA_f.sx} - {2'b00, b_sum_x[TB+31:TB]})
                                 : ({{2{rA_f.sx[31]}}, rA_f.sx} + {2'b00, b_sum_x[TB+31:TB]});
    assign b_off_y = rA_f.dy[32] ? ({{2{rA_f.sy[31]}}, rA_f.sy} - {2'b00, b_sum_y[TB+31:TB]})
                                 : ({{2{rA_f.sy[31]}}, rA_f.sy} + {2'b00, b_sum_y[TB+31:TB]});

    always_comb begin
        case (rA_f.sel)
            cct_pkg::SEL_END: begin
                b_qx = rA_f.ex;
                b_qy = rA_f.ey;
            end
            cct_pkg::SEL_DIV: begin
                b_qx = b_off_x[31:0];
                b_qy = b_off_y[31:0];
            end
            default: begin
                b_qx = rA_f.sx;
                b_qy = rA_f.sy;
            end
        endcase
    end

    // Stage C: offset from nearest point and its squares.
    logic               rC_v;
    cct_pkg::t_front    rC_f;
    logic signed [31:0] rC_qx, rC_qy;
    logic signed [32:0] rC_ex, rC_ey;
    logic [61:0]        rC_ex2, rC_ey2, rC_qr2;
    logic               rC_eps_x, rC_eps_y, rC_r_x, rC_r_y;
    logic signed [32:0] c_ex, c_ey;
    logic [31:0]        c_mx, c_my;

    assign c_ex = {rB_f.cx[31], rB_f.cx} - {rB_qx[31], rB_qx};
    assign c_ey = {rB_f.cy[31], rB_f.cy} - {rB_qy[31], rB_qy};
    assign c_mx = mag33(c_ex);
    assign c_my = mag33(c_ey);

    // Stage D: hit decision and vector selection.
    logic               rD_v;
    logic               rD_cmd, rD_hit;
    logic signed [32:0] rD_vec_x, rD_vec_y;
    logic signed [31:0] rD_base_x, rD_base_y;
    logic [30:0]        rD_sr;
    logic [62:0]        d_e2;
    logic               d_touch, d_near;

    assign d_e2    = {1'b0, rC_ex2} + {1'b0, rC_ey2};
    assign d_touch = rC_eps_x && rC_eps_y && (64'(d_e2) < EPS2);
    assign d_near  = rC_r_x && rC_r_y && (d_e2 < {1'b0, rC_qr2});

    // Stages E, F, G: scaled magnitudes and their squared length.
    cct_pkg::t_back r_e_b, rF_b, rG_b;
    logic           rE_v, rF_v, rG_v;
    logic [61:0]    rF_ax2, rF_ay2;
    logic [62:0]    rG_s;
    logic [31:0]    e_ax, e_ay;
    logic           e_shift;

    assign e_ax    = mag33(rD_vec_x);
    assign e_ay    = mag33(rD_vec_y);
    assign e_shift = e_ax[31] || e_ay[31];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rA_f  <= dA_f;
            rA_px <= 62'(mag33(dA_f.dx)) * 62'(t_quo);
            rA_py <= 62'(mag33(dA_f.dy)) * 62'(t_quo);

            rB_f  <= rA_f;
            rB_qx <= b_qx;
            rB_qy <= b_qy;

            rC_f     <= rB_f;
            rC_qx    <= rB_qx;
            rC_qy    <= rB_qy;
            rC_ex    <= c_ex;
            rC_ey    <= c_ey;
            rC_ex2   <= 62'(c_mx[30:0]) * 62'(c_mx[30:0]);
            rC_ey2   <= 62'(c_my[30:0]) * 62'(c_my[30:0]);
            rC_qr2   <= 62'(rB_f.qr) * 62'(rB_f.qr);
            rC_eps_x <= {1'b0, c_mx} < EPS;
            rC_eps_y <= {1'b0, c_my} < EPS;
            rC_r_x   <= c_mx < {1'b0, rB_f.qr};
            rC_r_y   <= c_my < {1'b0, rB_f.qr};

            rD_cmd <= rC_f.cmd;
            rD_sr  <= rC_f.sr;
            if (rC_f.cmd == cct_pkg::CMD_CIRCLE) begin
                rD_hit    <= rC_f.hit_c;
                rD_vec_x  <= rC_f.vx;
                rD_vec_y  <= rC_f.vy;
                rD_base_x <= rC_f.sx;
                rD_base_y <= rC_f.sy;
            end else begin
                rD_hit    <= d_touch || d_near;
                rD_vec_x  <= d_touch ? -rC_f.dy : rC_ex;
                rD_vec_y  <= d_touch ? rC_f.dx : rC_ey;
                rD_base_x <= rC_qx;
                rD_base_y <= rC_qy;
            end

            r_e_b.cmd    <= rD_cmd;
            r_e_b.hit    <= rD_hit;
            r_e_b.ax     <= e_shift ? e_ax[31:1] : e_ax[30:0];
            r_e_b.ay     <= e_shift ? e_ay[31:1] : e_ay[30:0];
            r_e_b.neg_x  <= rD_vec_x[32];
            r_e_b.neg_y  <= rD_vec_y[32];
            r_e_b.base_x <= rD_base_x;
            r_e_b.base_y <= rD_base_y;
            r_e_b.sr     <= rD_sr;

            rF_b   <= r_e_b;
            rF_ax2 <= 62'(r_e_b.ax) * 62'(r_e_b.ax);
            rF_ay2 <= 62'(r_e_b.ay) * 62'(r_e_b.ay);

            rG_b <= rF_b;
            rG_s <= {1'b0, rF_ax2} + {1'b0, rF_ay2};
        end
    end

    // Length of the normal vector.
    logic [LB-1:0]  sq_len;
    logic           sq_v;
    cct_pkg::t_back sq_b;

    cct_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_rad (rG_s),
        .o_root(sq_len)
    );

    cct_delay #(
        .W    ($bits(cct_pkg::t_back)),
        .DEPTH(LB)
    ) u_sqdly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_valid(rG_v),
        .i_data (rG_b),
        .o_valid(sq_v),
        .o_data (sq_b)
    );

    // Stage H: rounded numerators for the scaling divisions.
    logic           rH_v;
    cct_pkg::t_tail rH_tail;
    logic [LB-1:0]  rH_len;
    logic [62:0]    rH_nnx, rH_nny, rH_ncx, rH_ncy;
    logic [62:0]    h_half;

    assign h_half = 63'(sq_len >> 1);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rH_tail.cmd      <= sq_b.cmd;
            rH_tail.hit      <= sq_b.hit;
            rH_tail.neg_x    <= sq_b.neg_x;
            rH_tail.neg_y    <= sq_b.neg_y;
            rH_tail.base_x   <= sq_b.base_x;
            rH_tail.base_y   <= sq_b.base_y;
            rH_tail.len_zero <= (sq_len == '0);
            rH_len <= sq_len;
            rH_nnx <= 63'(sq_b.ax) * 63'(cct_pkg::UNIT_Q14) + h_half;
            rH_nny <= 63'(sq_b.ay) * 63'(cct_pkg::UNIT_Q14) + h_half;
            rH_ncx <= 63'(sq_b.ax) * 63'(sq_b.sr) + h_half;
            rH_ncy <= 63'(sq_b.ay) * 63'(sq_b.sr) + h_half;
        end
    end

    logic [QB-1:0]  q_nx, q_ny, q_cx, q_cy;
    logic           dv_v;
    cct_pkg::t_tail dv_tail;

    cct_div #(.DW(LB), .QW(QB)) u_div_nx (
        .i_clk(i_clk), .i_en(adv), .i_num(rH_nnx), .i_den(rH_len), .o_quo(q_nx)
    );
    cct_div #(.DW(LB), .QW(QB)) u_div_ny (
        .i_clk(i_clk), .i_en(adv), .i_num(rH_nny), .i_den(rH_len), .o_quo(q_ny)
    );
    cct_div #(.DW(LB), .QW(QB)) u_div_cx (
        .i_clk(i_clk), .i_en(adv), .i_num(rH_ncx), .i_den(rH_len), .o_quo(q_cx)
    );
    cct_div #(.DW(LB), .QW(QB)) u_div_cy (
        .i_clk(i_clk), .i_en(adv), .i_num(rH_ncy), .i_den(rH_len), .o_quo(q_cy)
    );

    cct_delay #(
        .W    ($bits(cct_pkg::t_tail)),
        .DEPTH(QB)
    ) u_dvdly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_valid(rH_v),
        .i_data (rH_tail),
        .o_valid(dv_v),
        .o_data (dv_tail)
    );

    // Output register.
    logic               rI_v;
    logic               r_hit;
    logic signed [31:0] r_cx, r_cy;
    logic signed [15:0] r_nx, r_ny;
    logic signed [31:0] n_cx, n_cy;
    logic signed [15:0] n_nx, n_ny;

    always_comb begin
        n_cx = '0;
        n_cy = '0;
        n_nx = '0;
        n_ny = '0;
        if (dv_tail.hit) begin
            n_cx = dv_tail.base_x;
            n_cy = dv_tail.base_y;
            if (!dv_tail.len_zero) begin
                n_nx = unit_comp(q_nx, dv_tail.neg_x);
                n_ny = unit_comp(q_ny, dv_tail.neg_y);
                if (dv_tail.cmd == cct_pkg::CMD_CIRCLE) begin
                    n_cx = sat_add(dv_tail.base_x, q_cx, dv_tail.neg_x);
                    n_cy = sat_add(dv_tail.base_y, q_cy, dv_tail.neg_y);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= dv_tail.hit;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
            rD_v <= 1'b0;
            rE_v <= 1'b0;
            rF_v <= 1'b0;
            rG_v <= 1'b0;
            rH_v <= 1'b0;
            rI_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            rA_v <= dA_v;
            rB_v <= rA_v;
            rC_v <= rB_v;
            rD_v <= rC_v;
            rE_v <= rD_v;
            rF_v <= rE_v;
            rG_v <= rF_v;
            rH_v <= sq_v;
            rI_v <= dv_v;
        end
    end

    assign o_valid     = rI_v;
    assign o_hit       = r_hit;
    assign o_contact_x = r_cx;
    assign o_contact_y = r_cy;
    assign o_normal_x  = r_nx;
    assign o_normal_y  = r_ny;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_contact_x == 0) && (o_contact_y == 0) &&
                              (o_normal_x == 0) && (o_normal_y == 0))
        else $error("A miss carries a nonzero contact or normal.");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384) &&
                    (o_normal_y <= 16'sd16384) && (o_normal_y >= -16'sd16384))
        else $error("Normal component is out of the unit range.");

    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rH_v && (rH_len != 0) |-> (rH_nnx < (63'(rH_len) << QB)) &&
                                  (rH_ncx < (63'(rH_len) << QB)))
        else $error("Scaling quotient does not fit the divider.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(rH_v) && $stable(rG_v) && $stable(r1_v))
        else $error("Pipeline valid bits moved during a stall.");

endmodule

@@ design/cct_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_delay
// Enabled delay line that carries side data and its valid bit alongside a
// pipelined arithmetic unit of the same depth.
// ----------------------------------------------------------------------------
module cct_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]     r_data [DEPTH];
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= DEPTH'({r_valid, i_valid});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

@@ design/cct_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QW bits, so the upper DW bits of the numerator are below the divisor.
// ----------------------------------------------------------------------------
module cct_div #(
    parameter int DW = 32,
    parameter int QW = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_lq  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] lq_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_lq;

        if (k == 0) begin : g_first
            assign rem_in = i_num[DW+QW-1:QW];
            assign den_in = i_den;
            assign lq_in  = i_num[QW-1:0];
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign lq_in  = r_lq[k-1];
        end

        assign trial = {rem_in, lq_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};

        always_comb begin
            if (trial >= {1'b0, den_in}) begin
                n_rem = diff[DW-1:0];
                n_lq  = QW'({lq_in, 1'b1});
            end else begin
                n_rem = trial[DW-1:0];
                n_lq  = QW'({lq_in, 1'b0});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_lq[k]  <= n_lq;
            end
        end
    end

    assign o_quo = r_lq[QW-1];

endmodule

@@ design/cct_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_isqrt
// Pipelined integer square root (floor), one root bit per stage, working on
// the remainder of the radicand after the root found so far.
// ----------------------------------------------------------------------------
module cct_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cct_pkg::RAD_BITS-1:0]  i_rad,
    output logic [cct_pkg::LEN_BITS-1:0]  o_root
);

    localparam int LB = cct_pkg::LEN_BITS;
    localparam int RW = 2 * LB;

    logic [RW-1:0] r_rem  [LB];
    logic [LB-1:0] r_root [LB];

    for (genvar k = 0; k < LB; k++) begin : g_stage
        localparam int BIT = LB - 1 - k;
        logic [RW-1:0] rem_in;
        logic [LB-1:0] root_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] n_rem;
        logic [LB-1:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = RW'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign trial = (RW'(root_in) << (BIT + 1)) | (RW'(1) << (2 * BIT));

        always_comb begin
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (LB'(1) << BIT);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[LB-1];

endmodule

@@ test/circle_collision_tester_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_collision_tester_tb
// Self-checking bench for the circle collision tester. A directed table covers
// the extremes and the special cases, then random queries follow, many of them
// near-miss geometry. Results are checked against table rows or a predictor.
// ----------------------------------------------------------------------------
module circle_collision_tester_tb;

    localparam int  LATENCY   = 105;
    localparam int  N_RANDOM  = 1930;
    localparam int  LIMIT     = 400000;
    localparam int  EPS       = 16;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [30:0] qr;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic        [30:0] sr;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } t_query;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } t_contact;

    typedef struct {
        t_query   q;
        bit       typed;
        t_contact e;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_cmd;
    logic signed [31:0] i_query_cx;
    logic signed [31:0] i_query_cy;
    logic        [30:0] i_query_radius;
    logic signed [31:0] i_second_x;
    logic signed [31:0] i_second_y;
    logic        [30:0] i_second_radius;
    logic signed [31:0] i_end_x;
    logic signed [31:0] i_end_y;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_hit;
    logic signed [31:0] o_contact_x;
    logic signed [31:0] o_contact_y;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;

    t_contact contacts_due[$];
    t_row     table_rows[$];
    int       errors = 0;
    int       cycle = 0;
    int       n_hits = 0;
    int       n_checked = 0;

    circle_collision_tester dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_div(bit neg, longint unsigned prod,
                                         longint unsigned den);
        longint unsigned q;
        q = (prod + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void shrink(longint vx, longint vy, output longint unsigned ax,
                                   output longint unsigned ay, output longint unsigned len);
        ax = magnitude(vx);
        ay = magnitude(vy);
        while (ax >= 64'd2147483648 || ay >= 64'd2147483648) begin
            ax >>= 1;
            ay >>= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
    endfunction

    function automatic void unit_dir(longint vx, longint vy, output longint nx,
                                     output longint ny);
        longint unsigned ax, ay, len;
        shrink(vx, vy, ax, ay, len);
        nx = 0;
        ny = 0;
        if (len != 0) begin
            nx = round_div(vx < 0, ax * cct_pkg::UNIT_Q14, len);
            ny = round_div(vy < 0, ay * cct_pkg::UNIT_Q14, len);
            if (nx > cct_pkg::UNIT_Q14) nx = cct_pkg::UNIT_Q14;
            if (nx < -cct_pkg::UNIT_Q14) nx = -cct_pkg::UNIT_Q14;
            if (ny > cct_pkg::UNIT_Q14) ny = cct_pkg::UNIT_Q14;
            if (ny < -cct_pkg::UNIT_Q14) ny = -cct_pkg::UNIT_Q14;
        end
    endfunction

    function automatic bit inside_radius(longint ex, longint ey, longint unsigned r,
                                         bit closed);
        logic [127:0] a, b, c;
        a = magnitude(ex);
        b = magnitude(ey);
        c = r;
        if (closed) return a <= c && b <= c && a * a + b * b <= c * c;
        return a < c && b < c && a * a + b * b < c * c;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_contact predict_contact(t_query q);
        longint cx, cy, sx, sy, ex, ey, vx, vy, dx, dy, qx, qy, nx, ny, px, py;
        longint unsigned ax, ay, len, t, rs;
        logic signed [127:0] num, den, quo;
        logic hit;
        t_contact r;
        cx = q.cx; cy = q.cy; sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
        hit = 1'b0; px = 0; py = 0; nx = 0; ny = 0;
        if (q.cmd == cct_pkg::CMD_CIRCLE) begin
            vx = cx - sx;
            vy = cy - sy;
            rs = q.qr;
            rs += q.sr;
            if (inside_radius(vx, vy, rs, 1'b1)) begin
                hit = 1'b1;
                shrink(vx, vy, ax, ay, len);
                px = sx;
                py = sy;
                if (len != 0) begin
                    px += round_div(vx < 0, ax * q.sr, len);
                    py += round_div(vy < 0, ay * q.sr, len);
                end
                unit_dir(vx, vy, nx, ny);
            end
        end else begin
            dx = ex - sx;
            dy = ey - sy;
            num = (cx - sx) * dx + (cy - sy) * dy;
            den = dx * dx + dy * dy;
            if (den == 0 || num <= 0) begin
                qx = sx; qy = sy;
            end else if (num >= den) begin
                qx = ex; qy = ey;
            end else begin
                quo = (num <<< cct_pkg::T_BITS) / den;
                t = quo[63:0];
                qx = sx + round_div(dx < 0, magnitude(dx) * t, 64'd1 << cct_pkg::T_BITS);
                qy = sy + round_div(dy < 0, magnitude(dy) * t, 64'd1 << cct_pkg::T_BITS);
            end
            if (inside_radius(cx - qx, cy - qy, EPS, 1'b0)) begin
                hit = 1'b1;
                unit_dir(-dy, dx, nx, ny);
            end else if (inside_radius(cx - qx, cy - qy, q.qr, 1'b0)) begin
                hit = 1'b1;
                unit_dir(cx - qx, cy - qy, nx, ny);
            end
            if (hit) begin
                px = qx; py = qy;
            end
        end
        r.hit = hit;
        r.px = clamp32(px);
        r.py = clamp32(py);
        r.nx = nx[15:0];
        r.ny = ny[15:0];
        return r;
    endfunction

    task automatic add_row(logic cmd, int cx, int cy, int qr, int sx, int sy, int sr,
                           int ex, int ey, bit typed, t_contact e);
        t_row row;
        row.q = '{cmd, cx, cy, qr[30:0], sx, sy, sr[30:0], ex, ey};
        row.typed = typed;
        row.e = e;
        table_rows.push_back(row);
    endtask

    function automatic t_query random_query();
        t_query q;
        int k, v;
        q.cmd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            q.cx = $urandom; q.cy = $urandom; q.qr = 31'($urandom);
            q.sx = $urandom; q.sy = $urandom; q.sr = 31'($urandom);
            q.ex = $urandom; q.ey = $urandom;
        end else begin
            k = $urandom_range(0, 30);
            q.cx = $urandom;
            q.cy = $urandom;
            v = $urandom; q.sx = q.cx + (v >>> (31 - k));
            v = $urandom; q.sy = q.cy + (v >>> (31 - k));
            v = $urandom; q.ex = q.sx + (v >>> (31 - k));
            v = $urandom; q.ey = q.sy + (v >>> (31 - k));
            q.qr = 31'($urandom & ((32'd2 << k) - 1));
            q.sr = 31'($urandom & ((32'd2 << k) - 1));
        end
        return q;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, field, got, want);
        errors++;
    endtask

    task automatic send(t_query q, t_contact e);
        i_valid         <= 1'b1;
        i_cmd           <= q.cmd;
        i_query_cx      <= q.cx;
        i_query_cy      <= q.cy;
        i_query_radius  <= q.qr;
        i_second_x      <= q.sx;
        i_second_y      <= q.sy;
        i_second_radius <= q.sr;
        i_end_x         <= q.ex;
        i_end_y         <= q.ey;
        do @(posedge i_clk); while (o_stall);
        contacts_due.push_back(e);
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("timeout with %0d results outstanding", contacts_due.size());
            $display("[circle_collision_tester] ERROR");
            $finish;
        end
    end

    // Receiver stalls in phases: none, light, heavy and alternating.
    always @(posedge i_clk) begin
        case ((cycle / 64) % 4)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_stall <= cycle[0];
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (contacts_due.size() == 0) begin
                $display("unexpected transaction at cycle %0d", cycle);
                errors++;
            end else begin
                want = contacts_due.pop_front();
                n_checked++;
                if (want.hit) n_hits++;
                if (o_hit !== want.hit) report("hit", o_hit, want.hit);
                if (o_contact_x !== want.px) report("contact_x", o_contact_x, want.px);
                if (o_contact_y !== want.py) report("contact_y", o_contact_y, want.py);
                if (o_normal_x !== want.nx) report("normal_x", o_normal_x, want.nx);
                if (o_normal_y !== want.ny) report("normal_y", o_normal_y, want.ny);
            end
        end
    end

    initial begin
        t_query   q;
        t_contact e;
        int burst, gap, wait_cycles;
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_cmd <= cct_pkg::CMD_CIRCLE;
        i_query_cx <= '0; i_query_cy <= '0; i_query_radius <= '0;
        i_second_x <= '0; i_second_y <= '0; i_second_radius <= '0;
        i_end_x <= '0; i_end_y <= '0;

        add_row(cct_pkg::CMD_CIRCLE, 7, 9, 1, 7, 9, 1, 0, 0, 1, '{1'b1, 7, 9, 0, 0});
        add_row(cct_pkg::CMD_CIRCLE, 1000, 0, 5, 0, 0, 5, 0, 0, 1, '{1'b0, 0, 0, 0, 0});
        add_row(cct_pkg::CMD_CIRCLE, 10, 0, 5, 0, 0, 6, 0, 0, 1, '{1'b1, 6, 0, 16384, 0});
        add_row(cct_pkg::CMD_CIRCLE, 0, -10, 5, 0, 0, 6, 0, 0, 1,
                '{1'b1, 0, -6, 0, -16384});
        add_row(cct_pkg::CMD_CIRCLE, 32'h7FFFFFFF, 0, 0, 32'h7FFFFF9B, 0, 1000, 0, 0, 1,
                '{1'b1, 32'h7FFFFFFF, 0, 16384, 0});
        add_row(cct_pkg::CMD_CIRCLE, 32'h80000000, 0, 0, 32'h80000064, 0, 1000, 0, 0, 1,
                '{1'b1, 32'h80000000, 0, -16384, 0});
        add_row(cct_pkg::CMD_CIRCLE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1, '{1'b0, 0, 0, 0, 0});
        add_row(cct_pkg::CMD_CIRCLE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h80000000, 32'h80000000, 32'h7FFFFFFF, -1, -1, 0, '0);
        add_row(cct_pkg::CMD_CIRCLE, 30, 40, 20, 0, 0, 30, 0, 0, 0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 5, 5, 0, 5, 5, 0, 5, 5, 1, '{1'b1, 5, 5, 0, 0});
        add_row(cct_pkg::CMD_SEGMENT, 50, 5, 0, 0, 0, 0, 100, 0, 1,
                '{1'b1, 50, 0, 0, 16384});
        add_row(cct_pkg::CMD_SEGMENT, 50, 100, 200, 0, 0, 0, 100, 0, 1,
                '{1'b1, 50, 0, 0, 16384});
        add_row(cct_pkg::CMD_SEGMENT, 50, 100, 100, 0, 0, 0, 100, 0, 1,
                '{1'b0, 0, 0, 0, 0});
        add_row(cct_pkg::CMD_SEGMENT, -30, 0, 40, 0, 0, 0, 100, 0, 1,
                '{1'b1, 0, 0, -16384, 0});
        add_row(cct_pkg::CMD_SEGMENT, 130, 0, 40, 0, 0, 0, 100, 0, 1,
                '{1'b1, 100, 0, 16384, 0});
        add_row(cct_pkg::CMD_SEGMENT, 300, 300, 400, 0, 0, 0, 100, 100, 0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 17, 3, 1000, 0, 0, 0, 33, 7, 0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0,
                32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0);
        add_row(cct_pkg::CMD_SEGMENT, 3, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 0, 0, 0, 0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            send(table_rows[i].q,
                 table_rows[i].typed ? table_rows[i].e : predict_contact(table_rows[i].q));
        end

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (contacts_due.size() != 0) @(posedge i_clk);
            end else if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            q = random_query();
            send(q, predict_contact(q));
            if (burst > 0) burst--;
        end
        i_valid <= 1'b0;

        while (contacts_due.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < LATENCY + 20) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("checked %0d transactions, %0d of them hits, over circle and segment",
                 n_checked, n_hits);
        $display("queries including extremes, saturation and degenerate shapes");
        if (errors == 0) begin
            $display("[circle_collision_tester] OK");
        end else begin
            $display("[circle_collision_tester] ERROR");
        end
        $finish;
    end
endmodule
